// ===== hw/rtl/hcpg_pkg.sv =====
// Shared types, widths, register codes and helpers for the Hilbert curve point generator.
// Depends on nothing; every other file of the block imports it.
package hcpg_pkg;

	// Fixed field widths
	localparam int IDX_W  = 16;
	localparam int CFG_W  = 16;
	localparam int ORD_W  = 5;
	// Axis components only shrink after the first halving; one guard bit covers negation
	localparam int AXIS_W = 17;
	// Base corner collects origin plus a series bounded by three times the axis range
	localparam int BASE_W = 20;

	// Register reset values: 144 x 168 display with a 10-pixel margin
	localparam logic signed [CFG_W-1:0] RST_ORIGIN_X  = 16'sd10;
	localparam logic signed [CFG_W-1:0] RST_ORIGIN_Y  = 16'sd10;
	localparam logic signed [CFG_W-1:0] RST_X_AXIS_DX = 16'sd124;
	localparam logic signed [CFG_W-1:0] RST_X_AXIS_DY = 16'sd10;
	localparam logic signed [CFG_W-1:0] RST_Y_AXIS_DX = 16'sd10;
	localparam logic signed [CFG_W-1:0] RST_Y_AXIS_DY = 16'sd148;
	localparam logic [3:0]              RST_ORDER     = 4'd4;

	typedef enum logic [2:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_X_AXIS_DX   = 3'd2,
		REG_X_AXIS_DY   = 3'd3,
		REG_Y_AXIS_DX   = 3'd4,
		REG_Y_AXIS_DY   = 3'd5,
		REG_CURVE_ORDER = 3'd6
	} cfg_reg_t;

	// Per-word control that travels with the frame
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic [ORD_W-1:0] ord;
		logic             draw;
		logic             last;
		logic             invalid;
	} meta_t;

	// Current sub-frame: base corner and two axis vectors
	typedef struct packed {
		logic signed [BASE_W-1:0] bx;
		logic signed [BASE_W-1:0] by;
		logic signed [AXIS_W-1:0] ax;
		logic signed [AXIS_W-1:0] ay;
		logic signed [AXIS_W-1:0] cx;
		logic signed [AXIS_W-1:0] cy;
	} frame_t;

	// Halve, truncating toward zero
	function automatic logic signed [AXIS_W-1:0] half(input logic signed [AXIS_W-1:0] v);
		logic signed [AXIS_W-1:0] t;
		t = v + $signed({{(AXIS_W-1){1'b0}}, v[AXIS_W-1]});
		return t >>> 1;
	endfunction

endpackage

// ===== hw/rtl/hcpg_level.sv =====
// One level of the Hilbert descent: halve the axes and step into the sub-frame
// picked by one base-4 digit. Depends on hcpg_pkg.
module hcpg_level #(
	parameter int LVL = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hcpg_pkg::meta_t  meta_in,
	input  hcpg_pkg::frame_t frame_in,
	output hcpg_pkg::meta_t  meta_s1,
	output hcpg_pkg::frame_t frame_s1
);
	import hcpg_pkg::*;

	logic [1:0]               digit;
	logic                     active;
	logic signed [AXIS_W-1:0] hax, hay, hcx, hcy;
	frame_t                   nxt;

	// Pick this level's digit; levels past the index width read zero
	generate
		if (2 * (LVL - 1) < IDX_W) begin : g_digit
			assign digit = meta_in.idx[2*(LVL-1) +: 2];
		end else begin : g_zero
			assign digit = 2'b00;
		end
	endgenerate

	assign active = (meta_in.ord >= ORD_W'(LVL));

	assign hax = half(frame_in.ax);
	assign hay = half(frame_in.ay);
	assign hcx = half(frame_in.cx);
	assign hcy = half(frame_in.cy);

	// Select sub-frame
	always_comb begin
		nxt = frame_in;
		if (active) begin
			unique case (digit)
				2'd0: begin
					nxt.ax = hcx;
					nxt.ay = hcy;
					nxt.cx = hax;
					nxt.cy = hay;
				end
				2'd1: begin
					nxt.bx = frame_in.bx + BASE_W'(hax);
					nxt.by = frame_in.by + BASE_W'(hay);
					nxt.ax = hax;
					nxt.ay = hay;
					nxt.cx = hcx;
					nxt.cy = hcy;
				end
				2'd2: begin
					nxt.bx = frame_in.bx + BASE_W'(hax) + BASE_W'(hcx);
					nxt.by = frame_in.by + BASE_W'(hay) + BASE_W'(hcy);
					nxt.ax = hax;
					nxt.ay = hay;
					nxt.cx = hcx;
					nxt.cy = hcy;
				end
				default: begin
					nxt.bx = frame_in.bx + BASE_W'(hax) + BASE_W'(frame_in.cx);
					nxt.by = frame_in.by + BASE_W'(hay) + BASE_W'(frame_in.cy);
					nxt.ax = -hcx;
					nxt.ay = -hcy;
					nxt.cx = -hax;
					nxt.cy = -hay;
				end
			endcase
		end
	end

	// Advance valid bit and word control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else begin
			meta_s1 <= meta_in;
		end
	end

	// Advance frame
	always_ff @(posedge clk) begin
		frame_s1 <= nxt;
	end

endmodule

// ===== hw/rtl/hilbert_curve_point_generator.sv =====
// Top level of the Hilbert curve point generator: config registers, index check,
// one pipeline stage per curve level, centre and saturation. Depends on hcpg_pkg, hcpg_level.
//
//  channel   handshake          payload
//  --------  -----------------  -------------------------------------------------
//  config    cfg_wr_en          cfg_index, cfg_data
//  input     start && !busy     point_index
//  result    done (one cycle)   point_x, point_y, draw_line, last_point, index_invalid
//
// One word enters per clock; busy stays low. Each word passes through an input stage,
// one stage per curve level (MAX_ORDER of them, unused levels pass
// the frame through), and a centre/saturate stage. Reset clears all valid bits and
// loads the register defaults. The receiver cannot stall, so the pipe never holds.
module hilbert_curve_point_generator #(
	parameter int MAX_ORDER   = 8,
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [2:0]                          cfg_index,
	input  logic [hcpg_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                start,
	output logic                                busy,
	input  logic [hcpg_pkg::IDX_W-1:0]          point_index,
	output logic                                done,
	output logic signed [COORD_WIDTH-1:0]       point_x,
	output logic signed [COORD_WIDTH-1:0]       point_y,
	output logic                                draw_line,
	output logic                                last_point,
	output logic                                index_invalid
);
	import hcpg_pkg::*;

	localparam int LAT = MAX_ORDER + 2;
	localparam int SW  = (COORD_WIDTH > BASE_W) ? COORD_WIDTH + 1 : BASE_W + 1;
	localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

	// Configuration registers
	logic signed [CFG_W-1:0] origin_x_q, origin_y_q;
	logic signed [CFG_W-1:0] x_axis_dx_q, x_axis_dy_q, y_axis_dx_q, y_axis_dy_q;
	logic [3:0]              curve_order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= RST_ORIGIN_X;
			origin_y_q    <= RST_ORIGIN_Y;
			x_axis_dx_q   <= RST_X_AXIS_DX;
			x_axis_dy_q   <= RST_X_AXIS_DY;
			y_axis_dx_q   <= RST_Y_AXIS_DX;
			y_axis_dy_q   <= RST_Y_AXIS_DY;
			curve_order_q <= RST_ORDER;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ORIGIN_X:    origin_x_q    <= cfg_data;
				REG_ORIGIN_Y:    origin_y_q    <= cfg_data;
				REG_X_AXIS_DX:   x_axis_dx_q   <= cfg_data;
				REG_X_AXIS_DY:   x_axis_dy_q   <= cfg_data;
				REG_Y_AXIS_DX:   y_axis_dx_q   <= cfg_data;
				REG_Y_AXIS_DY:   y_axis_dy_q   <= cfg_data;
				REG_CURVE_ORDER: curve_order_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Clamp order and check the index against four to the order
	logic [ORD_W-1:0] ord_c;
	logic [ORD_W:0]   nbits;
	logic             inv_c, low_ones, fits;

	assign ord_c = (ORD_W'(curve_order_q) > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER)
	                                                            : ORD_W'(curve_order_q);
	assign nbits = {ord_c, 1'b0};
	assign fits  = (nbits <= (ORD_W + 1)'(IDX_W));

	always_comb begin
		inv_c    = 1'b0;
		low_ones = 1'b1;
		for (int b = 0; b < IDX_W; b++) begin
			if ((ORD_W + 1)'(b) >= nbits) begin
				inv_c = inv_c | point_index[b];
			end else begin
				low_ones = low_ones & point_index[b];
			end
		end
	end

	// Input stage
	meta_t  meta_s0;
	frame_t frame_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s0 <= '0;
		end else begin
			meta_s0.valid   <= start && !busy;
			meta_s0.idx     <= point_index;
			meta_s0.ord     <= ord_c;
			meta_s0.draw    <= (point_index != '0);
			meta_s0.last    <= !inv_c && low_ones && fits;
			meta_s0.invalid <= inv_c;
		end
	end

	always_ff @(posedge clk) begin
		frame_s0.bx     <= BASE_W'(origin_x_q);
		frame_s0.by     <= BASE_W'(origin_y_q);
		frame_s0.ax     <= AXIS_W'(x_axis_dx_q);
		frame_s0.ay     <= AXIS_W'(x_axis_dy_q);
		frame_s0.cx     <= AXIS_W'(y_axis_dx_q);
		frame_s0.cy     <= AXIS_W'(y_axis_dy_q);
	end

	// Level stages, top level first
	meta_t  lvl_meta  [0:MAX_ORDER];
	frame_t lvl_frame [0:MAX_ORDER];

	assign lvl_meta[0]  = meta_s0;
	assign lvl_frame[0] = frame_s0;

	generate
		for (genvar g = 0; g < MAX_ORDER; g++) begin : g_lvl
			hcpg_level #(.LVL(MAX_ORDER - g)) u_level (
				.clk      (clk),
				.arst_n   (arst_n),
				.meta_in  (lvl_meta[g]),
				.frame_in (lvl_frame[g]),
				.meta_s1  (lvl_meta[g+1]),
				.frame_s1 (lvl_frame[g+1])
			);
		end
	endgenerate

	// Frame centre and saturation
	meta_t                    mf;
	frame_t                   ff;
	logic signed [AXIS_W:0]   sum_x, sum_y, ctr_x, ctr_y;
	logic signed [SW-1:0]     ext_x, ext_y, sat_x, sat_y;

	assign mf    = lvl_meta[MAX_ORDER];
	assign ff    = lvl_frame[MAX_ORDER];
	assign sum_x = (AXIS_W + 1)'(ff.ax) + (AXIS_W + 1)'(ff.cx);
	assign sum_y = (AXIS_W + 1)'(ff.ay) + (AXIS_W + 1)'(ff.cy);
	assign ctr_x = (sum_x + $signed({{AXIS_W{1'b0}}, sum_x[AXIS_W]})) >>> 1;
	assign ctr_y = (sum_y + $signed({{AXIS_W{1'b0}}, sum_y[AXIS_W]})) >>> 1;
	assign ext_x = SW'(ff.bx) + SW'(ctr_x);
	assign ext_y = SW'(ff.by) + SW'(ctr_y);

	always_comb begin
		priority if (ext_x > CMAX) sat_x = CMAX;
		else if (ext_x < CMIN)     sat_x = CMIN;
		else                       sat_x = ext_x;
		priority if (ext_y > CMAX) sat_y = CMAX;
		else if (ext_y < CMIN)     sat_y = CMIN;
		else                       sat_y = ext_y;
	end

	// Output register; drop fields of an out-of-range index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= mf.valid;
		end
	end

	always_ff @(posedge clk) begin
		point_x       <= mf.invalid ? '0 : sat_x[COORD_WIDTH-1:0];
		point_y       <= mf.invalid ? '0 : sat_y[COORD_WIDTH-1:0];
		draw_line     <= mf.draw && !mf.invalid;
		last_point    <= mf.last && !mf.invalid;
		index_invalid <= mf.invalid;
	end

	// Every accepted word comes out on done once it has passed through the whole pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted word did not complete after pipeline latency");

	// An out-of-range index carries no coordinates or flags
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_invalid) |->
			(point_x == '0 && point_y == '0 && !draw_line && !last_point))
		else $error("invalid index produced nonzero fields");

	// The last vertex of a curve of order one or more always joins the previous one
	a_last_draws: assert property (@(posedge clk) disable iff (!arst_n)
		(mf.valid && mf.last && mf.ord != '0) |=> (done && draw_line))
		else $error("last vertex of a nonzero-order curve not drawn");

endmodule

// ===== tb/hcpg_checker.sv =====
// Checker for the Hilbert curve point generator: tracks the config registers, predicts each
// vertex word at input acceptance and compares it with the result strobe. Depends on hcpg_pkg.
module hcpg_checker #(
	parameter int MAX_ORDER   = 8,
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [2:0]                    cfg_index,
	input  logic [hcpg_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          start,
	input  logic                          busy,
	input  logic [hcpg_pkg::IDX_W-1:0]    point_index,
	input  logic                          done,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic                          draw_line,
	input  logic                          last_point,
	input  logic                          index_invalid,
	output int                            mismatches,
	output int                            in_flight
);
	import hcpg_pkg::*;

	// Sub-frame picked by one base-4 digit of the index
	typedef enum logic [1:0] {
		QUAD_SWAP  = 2'd0,
		QUAD_SHIFT = 2'd1,
		QUAD_DIAG  = 2'd2,
		QUAD_FLIP  = 2'd3
	} quadrant_t;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic                          draw;
		logic                          last;
		logic                          invalid;
	} vertex_t;

	// Shadow copy of the config registers
	longint      org_x, org_y, xa_dx, xa_dy, ya_dx, ya_dy;
	int unsigned order_reg;

	vertex_t expected_vertices[$];

	function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[COORD_WIDTH-1:0];
	endfunction

	// Walk the index digits from the top level down, then take the frame centre
	function automatic vertex_t hilbert_vertex(input logic [IDX_W-1:0] idx);
		vertex_t     v;
		int unsigned levels;
		longint      total;
		longint      bx, by, ax, ay, cx, cy;
		longint      hax, hay, hcx, hcy;
		quadrant_t   quad;
		levels = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
		total  = longint'(1) <<< (2 * levels);
		v = '{default: '0};
		if (longint'(idx) >= total) begin
			v.invalid = 1'b1;
			return v;
		end
		bx = org_x;
		by = org_y;
		ax = xa_dx;
		ay = xa_dy;
		cx = ya_dx;
		cy = ya_dy;
		for (int lvl = levels; lvl > 0; lvl--) begin
			quad = quadrant_t'(idx[2*(lvl-1) +: 2]);
			hax  = ax / 2;
			hay  = ay / 2;
			hcx  = cx / 2;
			hcy  = cy / 2;
			case (quad)
				QUAD_SWAP: begin
					ax = hcx; ay = hcy; cx = hax; cy = hay;
				end
				QUAD_SHIFT: begin
					bx = bx + hax; by = by + hay;
					ax = hax; ay = hay; cx = hcx; cy = hcy;
				end
				QUAD_DIAG: begin
					bx = bx + hax + hcx; by = by + hay + hcy;
					ax = hax; ay = hay; cx = hcx; cy = hcy;
				end
				default: begin
					bx = bx + hax + cx; by = by + hay + cy;
					ax = -hcx; ay = -hcy; cx = -hax; cy = -hay;
				end
			endcase
		end
		v.x    = clamp_coord(bx + (ax + cx) / 2);
		v.y    = clamp_coord(by + (ay + cy) / 2);
		v.draw = (idx != '0);
		v.last = (longint'(idx) == total - 1);
		return v;
	endfunction

	task automatic report(input string msg);
		if (mismatches < 10) $display("%s", msg);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		in_flight  = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		if (!arst_n) begin
			org_x     = longint'(RST_ORIGIN_X);
			org_y     = longint'(RST_ORIGIN_Y);
			xa_dx     = longint'(RST_X_AXIS_DX);
			xa_dy     = longint'(RST_X_AXIS_DY);
			ya_dx     = longint'(RST_Y_AXIS_DX);
			ya_dy     = longint'(RST_Y_AXIS_DY);
			order_reg = 32'(RST_ORDER);
			expected_vertices.delete();
		end else begin
			// Check the result word against the oldest prediction
			if (done === 1'b1) begin
				if (expected_vertices.size() == 0) begin
					report($sformatf("result with nothing pending: x=%0d y=%0d draw=%0b last=%0b inv=%0b",
						point_x, point_y, draw_line, last_point, index_invalid));
				end else begin
					want = expected_vertices.pop_front();
					if (point_x !== want.x || point_y !== want.y || draw_line !== want.draw ||
					    last_point !== want.last || index_invalid !== want.invalid)
						report($sformatf({"vertex mismatch: expected x=%0d y=%0d draw=%0b last=%0b ",
							"inv=%0b, got x=%0d y=%0d draw=%0b last=%0b inv=%0b"},
							want.x, want.y, want.draw, want.last, want.invalid,
							point_x, point_y, draw_line, last_point, index_invalid));
				end
			end
			// Predict the accepted word with the registers as they stand
			if (start === 1'b1 && busy === 1'b0)
				expected_vertices.push_back(hilbert_vertex(point_index));
			// Track register writes; unmapped indexes drop
			if (cfg_wr_en === 1'b1) begin
				case (cfg_index)
					REG_ORIGIN_X:    org_x = longint'($signed(cfg_data));
					REG_ORIGIN_Y:    org_y = longint'($signed(cfg_data));
					REG_X_AXIS_DX:   xa_dx = longint'($signed(cfg_data));
					REG_X_AXIS_DY:   xa_dy = longint'($signed(cfg_data));
					REG_Y_AXIS_DX:   ya_dx = longint'($signed(cfg_data));
					REG_Y_AXIS_DY:   ya_dy = longint'($signed(cfg_data));
					REG_CURVE_ORDER: order_reg = 32'(cfg_data[3:0]);
					default: ;
				endcase
			end
		end
		in_flight = expected_vertices.size();
	end

endmodule

// ===== tb/hilbert_curve_point_generator_tb.sv =====
// Testbench top for the Hilbert curve point generator: clock, reset, config phases and
// index stimulus with random gaps. Depends on hcpg_pkg, the block and hcpg_checker.
module hilbert_curve_point_generator_tb;
	import hcpg_pkg::*;

	localparam int         MAX_ORDER       = 8;
	localparam int         COORD_WIDTH     = 16;
	localparam int         CYCLE_LIMIT     = 100000;
	localparam int         SETTLE_CYCLES   = MAX_ORDER + 6;
	localparam int         RANDOM_PHASES   = 10;
	localparam int         POINTS_PER_PHASE = 188;
	localparam logic [2:0] REG_UNMAPPED    = 3'd7;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [2:0]                    cfg_index;
	logic [CFG_W-1:0]              cfg_data;
	logic                          start;
	logic                          busy;
	logic [IDX_W-1:0]              point_index;
	logic                          done;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic                          draw_line;
	logic                          last_point;
	logic                          index_invalid;
	int                            mismatches;
	int                            in_flight;

	// Stimulus shaping only: effective order and idle odds of the current phase
	int cur_order;
	int idle_odds;

	hilbert_curve_point_generator #(
		.MAX_ORDER(MAX_ORDER),
		.COORD_WIDTH(COORD_WIDTH)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy), .point_index(point_index),
		.done(done), .point_x(point_x), .point_y(point_y),
		.draw_line(draw_line), .last_point(last_point), .index_invalid(index_invalid)
	);

	hcpg_checker #(
		.MAX_ORDER(MAX_ORDER),
		.COORD_WIDTH(COORD_WIDTH)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy), .point_index(point_index),
		.done(done), .point_x(point_x), .point_y(point_y),
		.draw_line(draw_line), .last_point(last_point), .index_invalid(index_invalid),
		.mismatches(mismatches), .in_flight(in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		int cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == REG_CURVE_ORDER)
			cur_order = (int'(data[3:0]) > MAX_ORDER) ? MAX_ORDER : int'(data[3:0]);
		@(posedge clk);
	endtask

	// Hold start until the word is taken
	task automatic issue_point(input logic [IDX_W-1:0] idx);
		logic took;
		start       <= 1'b1;
		point_index <= idx;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic maybe_idle();
		if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
			start       <= 1'b0;
			point_index <= IDX_W'($urandom);
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted word has come back
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (in_flight != 0) @(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'($urandom_range(0, 400) - 200);
			3:       return 16'($urandom_range(0, 4000));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_order_word();
		logic [CFG_W-1:0] w;
		int               r;
		w = CFG_W'($urandom);
		r = $urandom_range(0, 9);
		if (r < 7)
			w[3:0] = 4'($urandom_range(1, MAX_ORDER));
		else if (r == 7)
			w[3:0] = 4'd0;
		else
			w[3:0] = 4'($urandom_range(MAX_ORDER + 1, 15));
		return w;
	endfunction

	// Mostly in-range indexes, with the curve ends, the first bad index and full-width noise
	function automatic logic [IDX_W-1:0] pick_index();
		int count;
		count = 1 << (2 * cur_order);
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return IDX_W'(count - 1);
			2:       return (count <= 65535) ? IDX_W'(count) : IDX_W'($urandom);
			3, 4:    return IDX_W'($urandom);
			default: return IDX_W'($urandom_range(0, count - 1));
		endcase
	endfunction

	initial begin
		cfg_reg_t r;
		clk_init: begin
			arst_n      = 1'b0;
			cfg_wr_en   = 1'b0;
			cfg_index   = REG_ORIGIN_X;
			cfg_data    = '0;
			start       = 1'b0;
			point_index = '0;
			cur_order   = int'(RST_ORDER);
			idle_odds   = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset frame, order 4: curve ends, first bad index, all digits
		issue_point(16'd0);
		issue_point(16'd1);
		issue_point(16'd2);
		issue_point(16'd3);
		issue_point(16'd255);
		issue_point(16'd256);
		issue_point(16'hFFFF);
		issue_point(16'h5555);
		issue_point(16'hAAAA);
		drain();

		// Order zero: single centre point; a write to the unmapped index must not land
		write_reg(REG_CURVE_ORDER, 16'd0);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		cfg_wr_en <= 1'b0;
		issue_point(16'd0);
		issue_point(16'd1);
		issue_point(16'hFFFF);
		drain();

		write_reg(REG_CURVE_ORDER, 16'd1);
		cfg_wr_en <= 1'b0;
		issue_point(16'd3);
		issue_point(16'd4);
		drain();

		// Largest frame at order 8: positive saturation
		write_reg(REG_ORIGIN_X, 16'h7FFF);
		write_reg(REG_ORIGIN_Y, 16'h7FFF);
		write_reg(REG_X_AXIS_DX, 16'h7FFF);
		write_reg(REG_X_AXIS_DY, 16'h7FFF);
		write_reg(REG_Y_AXIS_DX, 16'h7FFF);
		write_reg(REG_Y_AXIS_DY, 16'h7FFF);
		write_reg(REG_CURVE_ORDER, 16'd8);
		cfg_wr_en <= 1'b0;
		issue_point(16'd0);
		issue_point(16'hFFFF);
		issue_point(16'hAAAA);
		issue_point(16'h5555);
		drain();

		// Most negative frame, order above maximum with upper data bits set
		write_reg(REG_ORIGIN_X, 16'h8000);
		write_reg(REG_ORIGIN_Y, 16'h8000);
		write_reg(REG_X_AXIS_DX, 16'h8000);
		write_reg(REG_X_AXIS_DY, 16'h8000);
		write_reg(REG_Y_AXIS_DX, 16'h8000);
		write_reg(REG_Y_AXIS_DY, 16'h8000);
		write_reg(REG_CURVE_ORDER, 16'hFFFF);
		cfg_wr_en <= 1'b0;
		issue_point(16'd0);
		issue_point(16'hFFFF);
		issue_point(16'h8000);
		issue_point(16'h7FFF);
		drain();

		// Random settings, each followed by a run of indexes; every third phase and the last one run without gaps
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			r = r.first();
			do begin
				write_reg(r, (r == REG_CURVE_ORDER) ? pick_order_word() : pick_coord());
				r = r.next();
			end while (r != r.first());
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNMAPPED, CFG_W'($urandom));
			cfg_wr_en <= 1'b0;
			idle_odds = (ph == RANDOM_PHASES - 1 || ph % 3 == 2) ? 0 : $urandom_range(2, 5);
			for (int i = 0; i < POINTS_PER_PHASE; i++) begin
				maybe_idle();
				issue_point(pick_index());
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
